// ----- hw/rtl/sip_pkg.sv -----
package sip_pkg;

    localparam int COORD_W  = 18;              // coordinate width, 8 fraction bits
    localparam int DIFF_W   = COORD_W + 1;     // signed coordinate difference
    localparam int PROD_W   = 2 * DIFF_W;      // signed product of two differences
    localparam int MAG_W    = PROD_W - 1;      // magnitude of det, ns, nt
    localparam int LO_W     = DIFF_W;          // low slice of |ns| for split multiply
    localparam int HI_W     = MAG_W - LO_W;    // high slice of |ns|
    localparam int NUM_W    = COORD_W + MAG_W; // |d1| * |ns|
    localparam int DIV_STEPS = COORD_W;        // quotient bits, |q| < |d1|
    localparam int IN_W     = 8 * COORD_W;
    localparam int OUT_W    = 40;              // two coordinates padded to bytes

    // geometry stage -> multiplier stage
    typedef struct packed {
        logic                 hit;
        logic                 neg_x;
        logic                 neg_y;
        logic [COORD_W-1:0]   ax;
        logic [COORD_W-1:0]   ay;
        logic [COORD_W-1:0]   mag_x;
        logic [COORD_W-1:0]   mag_y;
        logic [MAG_W-1:0]     mag_ns;
        logic [MAG_W-1:0]     mag_det;
    } t_mag;

    // side data that rides along the divider
    typedef struct packed {
        logic                 hit;
        logic                 neg_x;
        logic                 neg_y;
        logic [COORD_W-1:0]   ax;
        logic [COORD_W-1:0]   ay;
    } t_side;

    // multiplier stage -> divider
    typedef struct packed {
        t_side                side;
        logic [NUM_W-1:0]     num_x;
        logic [NUM_W-1:0]     num_y;
        logic [MAG_W-1:0]     den;
    } t_divin;

    // divider -> output stage
    typedef struct packed {
        t_side                side;
        logic [COORD_W-1:0]   q_x;
        logic [COORD_W-1:0]   q_y;
    } t_divout;

endpackage

// ----- hw/rtl/sip_geom.sv -----
module sip_geom (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [sip_pkg::IN_W-1:0]    i_data,
    output logic                        o_valid,
    output sip_pkg::t_mag               o_mag
);
    import sip_pkg::*;

    logic [COORD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    // stage 1: differences
    logic                      r_v1;
    logic signed [DIFF_W-1:0]  r_d1x, r_d1y, r_d2x, r_d2y, r_ox, r_oy;
    logic [COORD_W-1:0]        r_ax1, r_ay1;
    // stage 2: products
    logic                      r_v2;
    logic signed [PROD_W-1:0]  r_p_a, r_p_b, r_p_c, r_p_d, r_p_e, r_p_f;
    logic signed [DIFF_W-1:0]  r_d1x2, r_d1y2;
    logic [COORD_W-1:0]        r_ax2, r_ay2;
    // stage 3: determinant and numerators
    logic                      r_v3;
    logic signed [PROD_W-1:0]  r_det, r_ns, r_nt;
    logic signed [DIFF_W-1:0]  r_d1x3, r_d1y3;
    logic [COORD_W-1:0]        r_ax3, r_ay3;
    // stage 4: range test and magnitudes
    logic                      r_v4;
    t_mag                      r_mag;
    t_mag                      n_mag;

    logic det_pos, ns_in, nt_in;
    logic [PROD_W-1:0] abs_det, abs_ns;
    logic [DIFF_W-1:0] abs_x, abs_y;

    assign {dy, dx, cy, cx, by, bx, ay, ax} = i_data;

    always_comb begin
        det_pos = !r_det[PROD_W-1];
        ns_in   = det_pos ? (r_ns > 0 && r_ns < r_det) : (r_ns < 0 && r_ns > r_det);
        nt_in   = det_pos ? (r_nt > 0 && r_nt < r_det) : (r_nt < 0 && r_nt > r_det);
        abs_det = det_pos ? r_det : -r_det;
        abs_ns  = r_ns[PROD_W-1] ? -r_ns : r_ns;
        abs_x   = r_d1x3[DIFF_W-1] ? -r_d1x3 : r_d1x3;
        abs_y   = r_d1y3[DIFF_W-1] ? -r_d1y3 : r_d1y3;
        n_mag.hit     = (r_det != 0) && ns_in && nt_in;
        n_mag.neg_x   = r_d1x3[DIFF_W-1] ^ r_ns[PROD_W-1] ^ r_det[PROD_W-1];
        n_mag.neg_y   = r_d1y3[DIFF_W-1] ^ r_ns[PROD_W-1] ^ r_det[PROD_W-1];
        n_mag.ax      = r_ax3;
        n_mag.ay      = r_ay3;
        n_mag.mag_x   = abs_x[COORD_W-1:0];
        n_mag.mag_y   = abs_y[COORD_W-1:0];
        n_mag.mag_ns  = abs_ns[MAG_W-1:0];
        n_mag.mag_det = abs_det[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1x <= $signed({1'b0, bx}) - $signed({1'b0, ax});
            r_d1y <= $signed({1'b0, by}) - $signed({1'b0, ay});
            r_d2x <= $signed({1'b0, dx}) - $signed({1'b0, cx});
            r_d2y <= $signed({1'b0, dy}) - $signed({1'b0, cy});
            r_ox  <= $signed({1'b0, cx}) - $signed({1'b0, ax});
            r_oy  <= $signed({1'b0, cy}) - $signed({1'b0, ay});
            r_ax1 <= ax;
            r_ay1 <= ay;

            r_p_a  <= r_d2x * r_d1y;
            r_p_b  <= r_d1x * r_d2y;
            r_p_c  <= r_d2x * r_oy;
            r_p_d  <= r_d2y * r_ox;
            r_p_e  <= r_d1x * r_oy;
            r_p_f  <= r_d1y * r_ox;
            r_d1x2 <= r_d1x;
            r_d1y2 <= r_d1y;
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;

            r_det  <= r_p_a - r_p_b;
            r_ns   <= r_p_c - r_p_d;
            r_nt   <= r_p_e - r_p_f;
            r_d1x3 <= r_d1x2;
            r_d1y3 <= r_d1y2;
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;

            r_mag  <= n_mag;
        end
    end

    assign o_valid = r_v4;
    assign o_mag   = r_mag;

endmodule

// ----- hw/rtl/sip_mul.sv -----
module sip_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sip_pkg::t_mag     i_mag,
    output logic              o_valid,
    output sip_pkg::t_divin   o_div
);
    import sip_pkg::*;

    // stage 5: split partial products, stage 6: combine
    logic                        r_v5, r_v6;
    logic [COORD_W+LO_W-1:0]     r_lo_x, r_lo_y;
    logic [COORD_W+HI_W-1:0]     r_hi_x, r_hi_y;
    t_side                       r_side5;
    logic [MAG_W-1:0]            r_den5;
    t_divin                      r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_x  <= i_mag.mag_x * i_mag.mag_ns[LO_W-1:0];
            r_lo_y  <= i_mag.mag_y * i_mag.mag_ns[LO_W-1:0];
            r_hi_x  <= i_mag.mag_x * i_mag.mag_ns[MAG_W-1:LO_W];
            r_hi_y  <= i_mag.mag_y * i_mag.mag_ns[MAG_W-1:LO_W];
            r_side5 <= '{hit: i_mag.hit, neg_x: i_mag.neg_x, neg_y: i_mag.neg_y,
                         ax: i_mag.ax, ay: i_mag.ay};
            r_den5  <= i_mag.mag_det;

            r_div.side  <= r_side5;
            r_div.den   <= r_den5;
            r_div.num_x <= NUM_W'(r_lo_x) + (NUM_W'(r_hi_x) << LO_W);
            r_div.num_y <= NUM_W'(r_lo_y) + (NUM_W'(r_hi_y) << LO_W);
        end
    end

    assign o_valid = r_v6;
    assign o_div   = r_div;

endmodule

// ----- hw/rtl/sip_div.sv -----
module sip_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sip_pkg::t_divin    i_div,
    output logic               o_valid,
    output sip_pkg::t_divout   o_res
);
    import sip_pkg::*;

    // one quotient bit per stage, restoring, both coordinates side by side
    logic                  r_v    [1:DIV_STEPS];
    logic [NUM_W-1:0]      r_rx   [1:DIV_STEPS];
    logic [NUM_W-1:0]      r_ry   [1:DIV_STEPS];
    logic [COORD_W-1:0]    r_qx   [1:DIV_STEPS];
    logic [COORD_W-1:0]    r_qy   [1:DIV_STEPS];
    logic [MAG_W-1:0]      r_den  [1:DIV_STEPS];
    t_side                 r_side [1:DIV_STEPS];

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        localparam int SH = DIV_STEPS - k;
        logic                prev_v;
        logic [NUM_W-1:0]    prev_rx, prev_ry;
        logic [COORD_W-1:0]  prev_qx, prev_qy;
        logic [MAG_W-1:0]    prev_den;
        t_side               prev_side;
        logic [NUM_W:0]      shd, tx, ty;

        // first stage takes the multiplier output, the others the stage before
        if (k == 1) begin : g_head
            assign prev_v    = i_valid;
            assign prev_rx   = i_div.num_x;
            assign prev_ry   = i_div.num_y;
            assign prev_qx   = '0;
            assign prev_qy   = '0;
            assign prev_den  = i_div.den;
            assign prev_side = i_div.side;
        end else begin : g_body
            assign prev_v    = r_v[k-1];
            assign prev_rx   = r_rx[k-1];
            assign prev_ry   = r_ry[k-1];
            assign prev_qx   = r_qx[k-1];
            assign prev_qy   = r_qy[k-1];
            assign prev_den  = r_den[k-1];
            assign prev_side = r_side[k-1];
        end

        always_comb begin
            shd = (NUM_W+1)'(prev_den) << SH;
            tx  = {1'b0, prev_rx} - shd;
            ty  = {1'b0, prev_ry} - shd;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[k]   <= tx[NUM_W] ? prev_rx : tx[NUM_W-1:0];
                r_ry[k]   <= ty[NUM_W] ? prev_ry : ty[NUM_W-1:0];
                r_qx[k]   <= {prev_qx[COORD_W-2:0], !tx[NUM_W]};
                r_qy[k]   <= {prev_qy[COORD_W-2:0], !ty[NUM_W]};
                r_den[k]  <= prev_den;
                r_side[k] <= prev_side;
            end
        end
    end

    assign o_valid    = r_v[DIV_STEPS];
    assign o_res.side = r_side[DIV_STEPS];
    assign o_res.q_x  = r_qx[DIV_STEPS];
    assign o_res.q_y  = r_qy[DIV_STEPS];

endmodule

// ----- hw/rtl/segment_intersection_point.sv -----
// Segment crossing unit.
// Slave channel (i_s_*): one transfer carries two segments, eight 18-bit
// unsigned coordinates with 8 fraction bits. Master channel (o_m_*): one
// transfer per input, tuser holds the hit flag and tdata the crossing point
// (zero when there is no strict crossing).
// Throughput: one transfer per cycle unless the receiver stalls the output.
// From input transfer to output valid: four stages of differences,
// products, determinant and range test, two stages of split multiply,
// eighteen stages of restoring division (one quotient bit each) and the
// output register that adds the signed quotient to the start point.
// The whole pipeline moves on one enable: it advances whenever the output
// register is empty or is being taken, so bubbles are not squeezed out;
// all stages move together. When the receiver holds i_m_tready low with a
// result waiting, every stage holds and o_s_tready drops; nothing is lost
// or repeated. Reset (synchronous, active low) clears all valid bits; the
// pipeline is ready as soon as reset is released.
module segment_intersection_point (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [sip_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // cross_x, cross_y, 4 bits zero
    output logic [sip_pkg::OUT_W-1:0] o_m_tdata,
    // hit
    output logic                      o_m_tuser
);
    import sip_pkg::*;

    logic      en;
    logic      geom_v, mul_v, div_v;
    t_mag      geom_mag;
    t_divin    mul_div;
    t_divout   div_res;

    logic                r_out_valid;
    logic                r_hit;
    logic [COORD_W-1:0]  r_cx, r_cy;
    logic [COORD_W:0]    n_px, n_py;

    // advance when the output slot is free or being drained
    assign en         = i_m_tready || !r_out_valid;
    assign o_s_tready = en;

    sip_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (geom_v),
        .o_mag   (geom_mag)
    );

    sip_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geom_v),
        .i_mag   (geom_mag),
        .o_valid (mul_v),
        .o_div   (mul_div)
    );

    sip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_v),
        .i_div   (mul_div),
        .o_valid (div_v),
        .o_res   (div_res)
    );

    // apply the quotient sign: truncation toward zero on the magnitude
    always_comb begin
        n_px = div_res.side.neg_x ? {1'b0, div_res.side.ax} - {1'b0, div_res.q_x}
                                  : {1'b0, div_res.side.ax} + {1'b0, div_res.q_x};
        n_py = div_res.side.neg_y ? {1'b0, div_res.side.ay} - {1'b0, div_res.q_y}
                                  : {1'b0, div_res.side.ay} + {1'b0, div_res.q_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= div_res.side.hit;
            r_cx  <= div_res.side.hit ? n_px[COORD_W-1:0] : '0;
            r_cy  <= div_res.side.hit ? n_py[COORD_W-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_hit;
    assign o_m_tdata  = {(OUT_W - 2*COORD_W)'(0), r_cy, r_cx};

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss result carries a nonzero point");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("pending result changed under stall");

endmodule
